### sv/odometry_pose_correction_unit_defines.svh
// Assertion macros shared by the pose correction RTL.
// No dependencies; the including module must provide clk and arst_n.
`ifndef ODOMETRY_POSE_CORRECTION_UNIT_DEFINES_SVH
`define ODOMETRY_POSE_CORRECTION_UNIT_DEFINES_SVH

// same-cycle implication, gated by reset
`define OPC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("opc: same-cycle check failed");

// next-cycle implication, gated by reset
`define OPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("opc: next-cycle check failed");

`endif

### sv/opc_pkg.sv
// Shared constants, register codes and the CORDIC arctangent table.
// No dependencies.
package opc_pkg;

	localparam int POS_WIDTH_DEF     = 32;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// CORDIC datapath: 64-bit x/y, 33-bit signed angle accumulator
	localparam int CORDIC_W = 64;
	localparam int ZW       = 33;

	// 1/K in Q0.30
	localparam logic [29:0] INV_GAIN  = 30'd652032874;
	localparam int          INV_SHIFT = 30;

	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam logic [30:0] MIN_TRANS_RESET = 31'd3277;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ODOM_REF_X     = 3'd0,
		REG_ODOM_REF_Y     = 3'd1,
		REG_ODOM_REF_HEAD  = 3'd2,
		REG_GLOBAL_REF_X   = 3'd3,
		REG_GLOBAL_REF_Y   = 3'd4,
		REG_GLOBAL_REF_HEAD = 3'd5,
		REG_MIN_TRANS      = 3'd6
	} cfg_reg_t;

	// atan(2^-i) as a 32-bit full-turn angle
	function automatic logic [31:0] opc_atan(input int unsigned i);
		logic [31:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

### sv/opc_pose_if.sv
// Input channel: raw odometry pose with valid/ready.
// Depends on opc_pkg.
interface opc_pose_if import opc_pkg::*; #(
	parameter int PW = POS_WIDTH_DEF,
	parameter int AW = ANGLE_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [PW-1:0] odom_x;
	logic signed [PW-1:0] odom_y;
	logic signed [AW-1:0] odom_heading;

	modport source(output valid, odom_x, odom_y, odom_heading, input ready);
	modport sink(input valid, odom_x, odom_y, odom_heading, output ready);
endinterface

### sv/opc_corr_if.sv
// Output channel: corrected global pose with valid/ready.
// Depends on opc_pkg.
interface opc_corr_if import opc_pkg::*; #(
	parameter int PW = POS_WIDTH_DEF,
	parameter int AW = ANGLE_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [PW-1:0] corrected_x;
	logic signed [PW-1:0] corrected_y;
	logic signed [AW-1:0] corrected_heading;
	logic                 moving_backwards;

	modport source(output valid, corrected_x, corrected_y, corrected_heading,
		moving_backwards, input ready);
	modport sink(input valid, corrected_x, corrected_y, corrected_heading,
		moving_backwards, output ready);
endinterface

### sv/opc_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on opc_pkg.
interface opc_cfg_if import opc_pkg::*; #(
	parameter int DW = 32
);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DW-1:0]        data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### sv/odometry_pose_correction_unit.sv
// Throughput: one pose per cycle while no result waits at the output; every stage is a register, the two CORDIC chains
// are rows of cells that each move one step per cycle.
// The whole pipeline holds while a result waits at the output.
// Reset (arst_n low) clears the stage valid bits and loads register reset values.
// Depends on opc_pkg, opc_pose_if, opc_corr_if, opc_cfg_if, opc_cordic_cell and the defines header.
`include "odometry_pose_correction_unit_defines.svh"

module odometry_pose_correction_unit import opc_pkg::*; #(
	parameter int POS_WIDTH     = POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	opc_cfg_if.sink    cfg,
	opc_pose_if.sink   pose_in,
	opc_corr_if.source pose_out
);
	localparam int PW    = POS_WIDTH;
	localparam int AW    = ANGLE_WIDTH;
	localparam int CS    = CORDIC_STAGES;
	localparam int CW    = CORDIC_W;
	localparam int GUARD = 60 - PW;
	localparam int NST   = 2 * CS + 9;
	localparam logic signed [CW-1:0] RND = CW'(64'd1 << (GUARD - 1));
	localparam logic [31:0] ANG_HALF_LSB = 32'(64'd1 << (31 - AW));

	// ---------------- configuration registers ----------------
	logic signed [PW-1:0] oxr_q, oyr_q, gxr_q, gyr_q;
	logic        [AW-1:0] ohr_q, ghr_q;
	logic        [30:0]   mint_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oxr_q  <= '0;
			oyr_q  <= '0;
			ohr_q  <= '0;
			gxr_q  <= '0;
			gyr_q  <= '0;
			ghr_q  <= '0;
			mint_q <= MIN_TRANS_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ODOM_REF_X:      oxr_q  <= cfg.data[PW-1:0];
				REG_ODOM_REF_Y:      oyr_q  <= cfg.data[PW-1:0];
				REG_ODOM_REF_HEAD:   ohr_q  <= cfg.data[AW-1:0];
				REG_GLOBAL_REF_X:    gxr_q  <= cfg.data[PW-1:0];
				REG_GLOBAL_REF_Y:    gyr_q  <= cfg.data[PW-1:0];
				REG_GLOBAL_REF_HEAD: ghr_q  <= cfg.data[AW-1:0];
				REG_MIN_TRANS:       mint_q <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic           adv;
	logic [NST-1:0] v_q;

	assign adv           = !v_q[NST-1] || pose_out.ready;
	assign pose_in.ready = adv;
	assign pose_out.valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-2:0], pose_in.valid};
		end
	end

	// ---------------- stage 1: deltas and CORDIC pre-rotation ----------------
	logic        [PW-1:0] ddx, ddy;
	logic signed [CW-1:0] dx, dy;
	logic        [31:0]   rang, rang_q;
	logic                 rflip;

	assign ddx   = PW'(pose_in.odom_x - oxr_q);
	assign ddy   = PW'(pose_in.odom_y - oyr_q);
	assign dx    = CW'($signed(ddx)) <<< GUARD;
	assign dy    = CW'($signed(ddy)) <<< GUARD;
	assign rang  = 32'd0 - {pose_in.odom_heading, (32 - AW)'(0)};
	assign rang_q = rang + QUARTER_TURN;
	assign rflip = rang_q[31];

	logic signed [CW-1:0] ra_x [CS+1];
	logic signed [CW-1:0] ra_y [CS+1];
	logic        [ZW-1:0] ra_z [CS+1];
	logic signed [CW-1:0] va_x [CS+1];
	logic signed [CW-1:0] va_y [CS+1];
	logic        [ZW-1:0] va_z [CS+1];
	logic        [AW-1:0] oh_a [CS+1];
	logic                 zero_a [CS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			// back-motion test: rotate by minus heading, halved into +-quarter turn
			ra_x[0] <= rflip ? -dx : dx;
			ra_y[0] <= rflip ? -dy : dy;
			ra_z[0] <= ZW'($signed(rflip ? (rang ^ HALF_TURN) : rang));
			// bearing and length: vector from the right half plane
			va_x[0] <= dx[CW-1] ? -dx : dx;
			va_y[0] <= dx[CW-1] ? -dy : dy;
			va_z[0] <= dx[CW-1] ? {1'b0, HALF_TURN} : '0;
			oh_a[0]   <= pose_in.odom_heading;
			zero_a[0] <= (dx == '0) && (dy == '0);
		end
	end

	// ---------------- chain A: rotate and vector lanes ----------------
	for (genvar k = 0; k < CS; k++) begin : g_chain_a
		opc_cordic_cell #(.SHIFT(k), .VECTOR_MODE(1'b0)) u_rot (
			.clk(clk), .adv(adv),
			.x_in(ra_x[k]), .y_in(ra_y[k]), .z_in(ra_z[k]),
			.x_q(ra_x[k+1]), .y_q(ra_y[k+1]), .z_q(ra_z[k+1])
		);
		opc_cordic_cell #(.SHIFT(k), .VECTOR_MODE(1'b1)) u_vec (
			.clk(clk), .adv(adv),
			.x_in(va_x[k]), .y_in(va_y[k]), .z_in(va_z[k]),
			.x_q(va_x[k+1]), .y_q(va_y[k+1]), .z_q(va_z[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				oh_a[k+1]   <= oh_a[k];
				zero_a[k+1] <= zero_a[k];
			end
		end
	end

	// ---------------- stage 2: length times 1/K, partial products ----------------
	logic [CW-1:0] mag;
	logic [CW-1:0] mhi_s2, mlo_s2;
	logic [31:0]   vang_s2;
	logic [AW-1:0] oh_s2;
	logic          back_s2;

	assign mag = zero_a[CS] ? '0 : va_x[CS];

	always_ff @(posedge clk) begin
		if (adv) begin
			mhi_s2  <= {30'd0, mag[CW-1:INV_SHIFT]} * {34'd0, INV_GAIN};
			mlo_s2  <= {34'd0, mag[INV_SHIFT-1:0]} * {34'd0, INV_GAIN};
			vang_s2 <= zero_a[CS] ? 32'd0 : va_z[CS][31:0];
			oh_s2   <= oh_a[CS];
			back_s2 <= ra_x[CS][CW-1];
		end
	end

	// ---------------- stage 3: combine partial products ----------------
	logic [CW-1:0] dt_s3;
	logic [31:0]   vang_s3;
	logic [AW-1:0] oh_s3;
	logic          back_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s3   <= mhi_s2 + (mlo_s2 >> INV_SHIFT);
			vang_s3 <= vang_s2;
			oh_s3   <= oh_s2;
			back_s3 <= back_s2;
		end
	end

	// ---------------- stage 4: rotation split ----------------
	logic [AW-1:0] dh, dr1_short, dr1_long, dr1;
	logic [31:0]   vang2, vang_rnd;
	logic          short_move;

	assign dh         = oh_s3 - ohr_q;
	assign short_move = (dt_s3 >> GUARD) < CW'(mint_q);
	assign dr1_short  = AW'($signed(dh) >>> 1);
	assign vang2      = back_s3 ? (vang_s3 + HALF_TURN) : vang_s3;
	assign vang_rnd   = vang2 + ANG_HALF_LSB;
	assign dr1_long   = vang_rnd[31 -: AW] - ohr_q;
	assign dr1        = short_move ? dr1_short : dr1_long;

	logic signed [CW-1:0] dt_s4;
	logic        [AW-1:0] dr1_s4, hd_s4;
	logic                 back_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s4   <= back_s3 ? -$signed(dt_s3) : $signed(dt_s3);
			dr1_s4  <= dr1;
			// dr1 + dr2 equals the raw heading change
			hd_s4   <= ghr_q + dh;
			back_s4 <= back_s3;
		end
	end

	// ---------------- stage 5: pre-rotation for the replay ----------------
	logic [31:0] gang, gang_q;
	logic        gflip;

	assign gang   = {AW'(ghr_q + dr1_s4), (32 - AW)'(0)};
	assign gang_q = gang + QUARTER_TURN;
	assign gflip  = gang_q[31];

	logic signed [CW-1:0] rb_x [CS+1];
	logic signed [CW-1:0] rb_y [CS+1];
	logic        [ZW-1:0] rb_z [CS+1];
	logic        [AW-1:0] hd_b [CS+1];
	logic                 back_b [CS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rb_x[0]   <= gflip ? -dt_s4 : dt_s4;
			rb_y[0]   <= '0;
			rb_z[0]   <= ZW'($signed(gflip ? (gang ^ HALF_TURN) : gang));
			hd_b[0]   <= hd_s4;
			back_b[0] <= back_s4;
		end
	end

	// ---------------- chain B: rotate by the global bearing ----------------
	for (genvar k = 0; k < CS; k++) begin : g_chain_b
		opc_cordic_cell #(.SHIFT(k), .VECTOR_MODE(1'b0)) u_rot (
			.clk(clk), .adv(adv),
			.x_in(rb_x[k]), .y_in(rb_y[k]), .z_in(rb_z[k]),
			.x_q(rb_x[k+1]), .y_q(rb_y[k+1]), .z_q(rb_z[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				hd_b[k+1]   <= hd_b[k];
				back_b[k+1] <= back_b[k];
			end
		end
	end

	// ---------------- stage 6: magnitudes ----------------
	logic [CW-1:0] ux_s6, uy_s6;
	logic          nx_s6, ny_s6;
	logic [AW-1:0] hd_s6;
	logic          back_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s6   <= rb_x[CS][CW-1];
			ny_s6   <= rb_y[CS][CW-1];
			ux_s6   <= rb_x[CS][CW-1] ? -rb_x[CS] : rb_x[CS];
			uy_s6   <= rb_y[CS][CW-1] ? -rb_y[CS] : rb_y[CS];
			hd_s6   <= hd_b[CS];
			back_s6 <= back_b[CS];
		end
	end

	// ---------------- stage 7: 1/K partial products ----------------
	logic [CW-1:0] xhi_s7, xlo_s7, yhi_s7, ylo_s7;
	logic          nx_s7, ny_s7;
	logic [AW-1:0] hd_s7;
	logic          back_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			xhi_s7  <= {30'd0, ux_s6[CW-1:INV_SHIFT]} * {34'd0, INV_GAIN};
			xlo_s7  <= {34'd0, ux_s6[INV_SHIFT-1:0]} * {34'd0, INV_GAIN};
			yhi_s7  <= {30'd0, uy_s6[CW-1:INV_SHIFT]} * {34'd0, INV_GAIN};
			ylo_s7  <= {34'd0, uy_s6[INV_SHIFT-1:0]} * {34'd0, INV_GAIN};
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			hd_s7   <= hd_s6;
			back_s7 <= back_s6;
		end
	end

	// ---------------- stage 8: signed scaled offsets ----------------
	logic [CW-1:0] rx, ry;
	logic signed [CW-1:0] sx_s8, sy_s8;
	logic [AW-1:0] hd_s8;
	logic          back_s8;

	assign rx = xhi_s7 + (xlo_s7 >> INV_SHIFT);
	assign ry = yhi_s7 + (ylo_s7 >> INV_SHIFT);

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s8   <= nx_s7 ? -$signed(rx) : $signed(rx);
			sy_s8   <= ny_s7 ? -$signed(ry) : $signed(ry);
			hd_s8   <= hd_s7;
			back_s8 <= back_s7;
		end
	end

	// ---------------- stage 9: round, add the global reference ----------------
	logic signed [CW-1:0] ex, ey;

	assign ex = (sx_s8 + RND) >>> GUARD;
	assign ey = (sy_s8 + RND) >>> GUARD;

	always_ff @(posedge clk) begin
		if (adv) begin
			pose_out.corrected_x       <= gxr_q + ex[PW-1:0];
			pose_out.corrected_y       <= gyr_q + ey[PW-1:0];
			pose_out.corrected_heading <= hd_s8;
			pose_out.moving_backwards  <= back_s8;
		end
	end

	// ---------------- assertions ----------------
	`OPC_ASSERT_IMPLY(a_stall_blocks_input, pose_out.valid && !pose_out.ready, !pose_in.ready)
	`OPC_ASSERT_IMPLY(a_empty_out_takes_input, !pose_out.valid, pose_in.ready)
	`OPC_ASSERT_NEXT(a_first_stage_moves, v_q[0] && adv, v_q[1])
	`OPC_ASSERT_IMPLY(a_cfg_always_ready, cfg.valid, cfg.ready)
endmodule

### sv/opc_cordic_cell.sv
// One CORDIC micro-rotation cell with registered outputs.
// Depends on opc_pkg (datapath widths, arctangent table).
module opc_cordic_cell import opc_pkg::*; #(
	parameter int SHIFT       = 0,
	parameter bit VECTOR_MODE = 1'b0
) (
	input  logic                       clk,
	input  logic                       adv,
	input  logic signed [CORDIC_W-1:0] x_in,
	input  logic signed [CORDIC_W-1:0] y_in,
	input  logic        [ZW-1:0]       z_in,
	output logic signed [CORDIC_W-1:0] x_q,
	output logic signed [CORDIC_W-1:0] y_q,
	output logic        [ZW-1:0]       z_q
);
	localparam logic [ZW-1:0] ATAN = {1'b0, opc_atan(SHIFT)};

	logic                       sigma;
	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;

	// rotation direction: drive y to zero when vectoring, z to zero when rotating
	assign sigma = VECTOR_MODE ? y_in[CORDIC_W-1] : !z_in[ZW-1];
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sigma) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end
		end
	end
endmodule
